/* rtl/sfq_pkg.sv */
package sfq_pkg;

  // Fixed field widths of the item formats
  localparam int FUNC_W   = 3;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 4;
  localparam int COUNT_W  = 5;
  localparam int CFG_W    = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH         = 3'd0,
    FN_POP          = 3'd1,
    FN_PEEK         = 3'd2,
    FN_FIND         = 3'd3,
    FN_REMOVE_AT    = 3'd4,
    FN_REMOVE_MATCH = 3'd5,
    FN_CLEAR        = 3'd6
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_APPLY
  } state_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic eval;    // capture hit flag
    logic by_pos;  // hit means "at target position" instead of "matches key"
    logic push;    // cell at the tail slot loads the key
    logic remove;  // cells at and after the removed slot take the neighbor's word
  } cell_cmd_t;

endpackage

/* rtl/searchable_fifo_queue_unit.sv */
// Searchable FIFO queue: an ordered queue of up to DEPTH words, head at position 0,
// held in a chain of cells. Each input item is one operation (push, pop, peek, find,
// remove at a position, remove the first match, clear) and yields exactly one result
// item with a status, the position found, the word read or removed and the entry count
// after the operation. An item is accepted when idle; in the match state every cell
// compares its word against the key under compare_mask (or against the target position)
// and registers a hit flag; in the apply state the first hit is picked, the cells close
// the gap or take the pushed word, and the result register loads. A new item is taken as
// soon as the result is in its register, so a waiting result does not block the next item
// until that one is ready to be delivered. A push to a full queue is dropped with status
// full. compare_mask is written by the user only while idle; the block does not enforce it.
module searchable_fifo_queue_unit
  import sfq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int IN_W      = ((DATA_WIDTH + POS_W + 7) / 8) * 8,
  localparam int OUT_W     = ((FOUND_W + DATA_WIDTH + COUNT_W + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration: compare_mask
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_W-1:0]          cfg_data,
  // operation items
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_W-1:0]           in_tdata,   // data_in, position
  input  logic [FUNC_W-1:0]         in_tuser,   // func
  // result items
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_W-1:0]          out_tdata,  // found_position, data_out, entry_count
  output logic [STATUS_W-1:0]       out_tuser   // status
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  state_t                          state_r, state_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic [DATA_WIDTH-1:0]           mask_r;

  // operation held while it runs
  func_t                           func_r;
  logic [DATA_WIDTH-1:0]           key_r;
  logic [POS_W-1:0]                pos_r;

  // result register
  logic                            out_valid_r;
  status_t                         out_status_r, status_nxt;
  logic [FOUND_W-1:0]              out_found_r, found_nxt;
  logic [DATA_WIDTH-1:0]           out_data_r, dout_nxt;
  logic [COUNT_W-1:0]              out_count_r;

  cell_cmd_t                       cmd;
  logic                            go, by_pos, pos_ok, push_ok, rm_ok;
  logic [POS_W-1:0]                target;
  logic [DEPTH-1:0]                hit;
  logic [DEPTH-1:0][DATA_WIDTH-1:0] cell_data;
  logic                            any_hit;
  logic [DEPTH-1:0]                first_hit;
  logic [IDX_W-1:0]                hit_idx;
  logic [DATA_WIDTH-1:0]           hit_data;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);

  // Pop works on the head; peek and remove_at on the given position
  assign by_pos = (func_r == FN_POP) || (func_r == FN_PEEK) || (func_r == FN_REMOVE_AT);
  assign target = (func_r == FN_POP) ? '0 : pos_r;
  assign pos_ok = CMP_W'(target) < CMP_W'(count_r);

  // Finish an operation only when the result register is free or being emptied
  assign go = (state_r == S_APPLY) && (!out_valid_r || out_tready);

  // ---------------------------------------------------------------------------
  // Chain of cells: each holds one entry, the last one refills from itself
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] nbr;
    if (g == DEPTH - 1) begin : g_tail
      assign nbr = cell_data[g];
    end else begin : g_mid
      assign nbr = cell_data[g+1];
    end

    sfq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .DEPTH      (DEPTH),
      .CELL_IDX   (g)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .key       (key_r),
      .mask      (mask_r),
      .target    (target),
      .count     (count_r),
      .rm_idx    (hit_idx),
      .next_data (nbr),
      .data_q    (cell_data[g]),
      .hit_q     (hit[g])
    );
  end

  sfq_pick #(
    .DATA_WIDTH (DATA_WIDTH),
    .DEPTH      (DEPTH)
  ) u_pick (
    .hit       (hit),
    .cell_data (cell_data),
    .any_hit   (any_hit),
    .first_hit (first_hit),
    .hit_idx   (hit_idx),
    .hit_data  (hit_data)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: next state, result fields and cell commands
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    status_nxt = STS_OK;
    found_nxt  = '0;
    dout_nxt   = '0;
    push_ok    = 1'b0;
    rm_ok      = 1'b0;

    case (func_r)
      FN_PUSH: begin
        if (count_r == CNT_W'(DEPTH)) begin
          status_nxt = STS_FULL;
        end else begin
          push_ok   = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      FN_POP, FN_REMOVE_AT: begin
        if (!pos_ok) begin
          status_nxt = STS_EMPTY;
        end else begin
          rm_ok     = 1'b1;
          dout_nxt  = hit_data;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      FN_PEEK: begin
        if (!pos_ok) begin
          status_nxt = STS_EMPTY;
        end else begin
          dout_nxt = hit_data;
        end
      end
      FN_FIND: begin
        if (!any_hit) begin
          status_nxt = STS_NOT_FOUND;
        end else begin
          found_nxt = FOUND_W'(hit_idx);
        end
      end
      FN_REMOVE_MATCH: begin
        if (!any_hit) begin
          status_nxt = STS_NOT_FOUND;
        end else begin
          rm_ok     = 1'b1;
          found_nxt = FOUND_W'(hit_idx);
          dout_nxt  = hit_data;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      FN_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        // unused code: leave the queue as it is
      end
    endcase

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    cmd.eval   = (state_r == S_MATCH);
    cmd.by_pos = by_pos;
    cmd.push   = go && push_ok;
    cmd.remove = go && rm_ok;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      mask_r      <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (go) begin
        count_r <= count_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        mask_r <= DATA_WIDTH'(cfg_data);
      end
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: hold the operation, load the result
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r <= func_t'(in_tuser);
      key_r  <= in_tdata[DATA_WIDTH-1:0];
      pos_r  <= in_tdata[DATA_WIDTH+POS_W-1:DATA_WIDTH];
    end
    if (go) begin
      out_status_r <= status_nxt;
      out_found_r  <= found_nxt;
      out_data_r   <= dout_nxt;
      out_count_r  <= COUNT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_W'({out_count_r, out_data_r, out_found_r});

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !go |=> $stable(count_r))
    else $error("entry count changed outside an operation");

  a_pos_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) && by_pos |-> $onehot0(hit) && (pos_ok == any_hit))
    else $error("positional hit flags disagree with range check");

  a_result_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_APPLY)
    else $error("result appeared without an operation finishing");

  a_first_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |-> $onehot0(first_hit) && (any_hit == (first_hit != '0)))
    else $error("first hit pick is not a single flag");

endmodule

/* rtl/sfq_cell.sv */
module sfq_cell
  import sfq_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int DEPTH      = 16,
  parameter int CELL_IDX   = 0
) (
  input  logic                          clk,
  input  cell_cmd_t                     cmd,
  input  logic [DATA_WIDTH-1:0]         key,
  input  logic [DATA_WIDTH-1:0]         mask,
  input  logic [POS_W-1:0]              target,
  input  logic [$clog2(DEPTH+1)-1:0]    count,
  input  logic [$clog2(DEPTH)-1:0]      rm_idx,
  input  logic [DATA_WIDTH-1:0]         next_data,
  output logic [DATA_WIDTH-1:0]         data_q,
  output logic                          hit_q
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic                  hit_r, hit_nxt;
  logic                  valid, match, at_target;

  assign valid     = CNT_W'(CELL_IDX) < count;
  assign match     = ((data_r ^ key) & mask) == '0;
  assign at_target = CMP_W'(CELL_IDX) == CMP_W'(target);

  always_comb begin
    data_nxt = data_r;
    if (cmd.push && (CNT_W'(CELL_IDX) == count)) begin
      data_nxt = key;
    end else if (cmd.remove && (IDX_W'(CELL_IDX) >= rm_idx)) begin
      data_nxt = next_data;
    end
  end

  always_comb begin
    hit_nxt = hit_r;
    if (cmd.eval) begin
      hit_nxt = valid && (cmd.by_pos ? at_target : match);
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    hit_r  <= hit_nxt;
  end

  assign data_q = data_r;
  assign hit_q  = hit_r;

endmodule

/* rtl/sfq_pick.sv */
module sfq_pick
  import sfq_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int DEPTH      = 16
) (
  input  logic [DEPTH-1:0]                 hit,
  input  logic [DEPTH-1:0][DATA_WIDTH-1:0] cell_data,
  output logic                             any_hit,
  output logic [DEPTH-1:0]                 first_hit,
  output logic [$clog2(DEPTH)-1:0]         hit_idx,
  output logic [DATA_WIDTH-1:0]            hit_data
);

  localparam int IDX_W = $clog2(DEPTH);

  // Isolate the lowest set flag: the first entry from the head
  assign first_hit = hit & (~hit + DEPTH'(1));
  assign any_hit   = |hit;

  always_comb begin
    hit_idx  = '0;
    hit_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_hit[i]) begin
        hit_idx  = hit_idx | IDX_W'(i);
        hit_data = hit_data | cell_data[i];
      end
    end
  end

endmodule

/* dv/tb_searchable_fifo_queue_unit.sv */
`timescale 1ns / 100ps

module tb_searchable_fifo_queue_unit;
  import sfq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int DATA_W      = 32;
  localparam int IN_TDATA_W  = 40;  // data_in, position, zero fill to whole bytes
  localparam int OUT_TDATA_W = 48;  // found_position, data_out, entry_count, zero fill
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_STALL  = 200;
  localparam int DRAIN_SLACK = 4;
  localparam int END_SLACK   = 12;
  localparam int ITEMS_PER_PHASE = 82;

  // func code 7 has no operation behind it: the block answers ok and keeps its state
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

  // One result item, split into its fields
  typedef struct packed {
    status_t              status;
    logic [FOUND_W-1:0]   found;
    logic [DATA_W-1:0]    word;
    logic [COUNT_W-1:0]   entries;
  } queue_result_t;

  // One row of the directed stimulus; typed rows carry their own expected result
  typedef struct {
    logic [FUNC_W-1:0] fn;
    logic [DATA_W-1:0] key;
    logic [POS_W-1:0]  pos;
    bit                typed;
    queue_result_t     exp;
  } op_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data = '0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [31:0] data_in, [35:32] position
  logic [FUNC_W-1:0]      in_tuser = '0;   // func

  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [3:0] found_position, [35:4] data_out,
                                           // [40:36] entry_count
  logic [STATUS_W-1:0]    out_tuser;       // status

  searchable_fifo_queue_unit #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_W)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Shadow of the queue: words, fill level and the search mask as the block should hold them
  logic [DATA_W-1:0] shadow_words [DEPTH];
  int unsigned       shadow_len = 0;
  logic [DATA_W-1:0] shadow_mask = '1;

  queue_result_t pending_results [$];
  op_row_t       directed_ops [$];

  int unsigned error_count = 0;
  int unsigned result_index = 0;
  int unsigned cycle_count = 0;

  // Idling controls, changed per phase by the stimulus
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  bit hold_off_req = 1'b0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Locate the first entry, from the head, that equals key in the masked bits
  function automatic bit search_first(input logic [DATA_W-1:0] key,
                                      output int unsigned at);
    at = 0;
    for (int i = 0; i < shadow_len; i++) begin
      if (((shadow_words[i] ^ key) & shadow_mask) == '0) begin
        at = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Pull one entry out and close the gap behind it
  function automatic logic [DATA_W-1:0] take_word(input int unsigned at);
    logic [DATA_W-1:0] w;
    w = shadow_words[at];
    for (int i = at; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i + 1];
    shadow_len--;
    return w;
  endfunction

  // Apply one operation to the shadow queue and return the result the block owes
  function automatic queue_result_t apply_queue_op(input logic [FUNC_W-1:0] fn,
                                                   input logic [DATA_W-1:0] key,
                                                   input logic [POS_W-1:0]  pos);
    queue_result_t r;
    int unsigned   at;
    r = '{status: STS_OK, found: '0, word: '0, entries: '0};
    case (fn)
      FN_PUSH: begin
        if (shadow_len >= DEPTH) begin
          r.status = STS_FULL;
        end else begin
          shadow_words[shadow_len] = key;
          shadow_len++;
        end
      end
      FN_POP: begin
        if (shadow_len == 0) r.status = STS_EMPTY;
        else r.word = take_word(0);
      end
      FN_PEEK: begin
        if (pos >= shadow_len) r.status = STS_EMPTY;
        else r.word = shadow_words[pos];
      end
      FN_FIND: begin
        if (search_first(key, at)) r.found = at[FOUND_W-1:0];
        else r.status = STS_NOT_FOUND;
      end
      FN_REMOVE_AT: begin
        if (pos >= shadow_len) r.status = STS_EMPTY;
        else r.word = take_word(pos);
      end
      FN_REMOVE_MATCH: begin
        if (search_first(key, at)) begin
          r.found = at[FOUND_W-1:0];
          r.word  = take_word(at);
        end else begin
          r.status = STS_NOT_FOUND;
        end
      end
      FN_CLEAR: shadow_len = 0;
      default: ;  // unused code: no change
    endcase
    r.entries = shadow_len[COUNT_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  // Print one line per mismatch (up to a cap) and count every one
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= 40)
      $display("ERROR t=%0t result %0d: %s got %0h expected %0h",
               $time, result_index, what, got, want);
  endtask

  // Compare every accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    queue_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status)
          report_mismatch("status", out_tuser, want.status);
        if (out_tdata[3:0] !== want.found)
          report_mismatch("found_position", out_tdata[3:0], want.found);
        if (out_tdata[35:4] !== want.word)
          report_mismatch("data_out", out_tdata[35:4], want.word);
        if (out_tdata[40:36] !== want.entries)
          report_mismatch("entry_count", out_tdata[40:36], want.entries);
      end
      result_index++;
    end
  end

  // Kill the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one; never zero
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin : rx_ready_gen
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        // hold the result side shut long enough for the input to back up
        out_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one operation, predict it at the accepting edge, then maybe idle.
  // valid stays high when no gap follows, so back-to-back items need no re-raise.
  task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] key,
                         input logic [POS_W-1:0] pos, input bit typed = 1'b0,
                         input queue_result_t typed_exp = '0);
    queue_result_t predicted;
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {{(IN_TDATA_W - DATA_W - POS_W){1'b0}}, pos, key};
    do @(posedge clk); while (!in_tready);
    predicted = apply_queue_op(fn, key, pos);
    pending_results.push_back(typed ? typed_exp : predicted);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every outstanding result, plus a little slack
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Write compare_mask with the block idle; the shadow picks it up on the handshake
  task automatic write_mask(input logic [CFG_W-1:0] m);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    shadow_mask = m;
    cfg_valid <= 1'b0;
  endtask

  // Word to push: often a small value so masked duplicates show up, else anything
  function automatic logic [DATA_W-1:0] push_word();
    if ($urandom_range(0, 9) < 4) return DATA_W'($urandom_range(0, 7));
    return $urandom();
  endfunction

  // Key for a search: mostly a stored entry with unmasked bits scrambled
  function automatic logic [DATA_W-1:0] search_key();
    if (shadow_len != 0 && $urandom_range(0, 9) < 8)
      return shadow_words[$urandom_range(0, shadow_len - 1)] ^ ($urandom() & ~shadow_mask);
    return $urandom();
  endfunction

  // Position: mostly a live one, sometimes anything the field allows
  function automatic logic [POS_W-1:0] pick_pos();
    if (shadow_len != 0 && $urandom_range(0, 99) < 85)
      return POS_W'($urandom_range(0, shadow_len - 1));
    return POS_W'($urandom_range(0, DEPTH - 1));
  endfunction

  // Random traffic built from short, well-formed sequences plus some noise
  task automatic run_random_ops(input int unsigned n_items, input bit start_full);
    int unsigned sent;
    int unsigned pick;
    int unsigned burst;
    sent = 0;
    if (start_full) begin
      // fill to the brim and push once more to hit the full case
      burst = DEPTH + 1 - shadow_len;
      repeat (burst) send_op(FN_PUSH, push_word(), POS_W'($urandom()));
      sent += burst;
    end
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        burst = ($urandom_range(0, 5) == 0) ? DEPTH + 1 - shadow_len : $urandom_range(1, 4);
        repeat (burst) send_op(FN_PUSH, push_word(), POS_W'($urandom()));
        sent += burst;
      end else if (pick < 48) begin
        send_op($urandom_range(0, 1) ? FN_FIND : FN_REMOVE_MATCH, search_key(),
                POS_W'($urandom()));
        sent++;
      end else if (pick < 64) begin
        send_op($urandom_range(0, 1) ? FN_PEEK : FN_REMOVE_AT, $urandom(), pick_pos());
        sent++;
      end else if (pick < 76) begin
        send_op(FN_POP, $urandom(), POS_W'($urandom()));
        sent++;
      end else if (pick < 79) begin
        send_op(FN_CLEAR, $urandom(), POS_W'($urandom()));
        sent++;
      end else if (pick < 82) begin
        // unused code: answered but does nothing, so not counted
        send_op(FN_UNUSED, $urandom(), POS_W'($urandom()));
      end else begin
        send_op(FUNC_W'($urandom_range(0, 7)), $urandom(), POS_W'($urandom()));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    logic [CFG_W-1:0] mask_plan [6];
    op_row_t row;

    // Directed part under the reset mask (all ones). Typed rows are read off the
    // spec directly; the rest go through the shadow model.
    directed_ops.push_back('{FN_POP,          32'h0000_0000, 4'd0,  1'b1,
                             '{STS_EMPTY,     4'd0, 32'h0, 5'd0}});
    directed_ops.push_back('{FN_PEEK,         32'h0000_0000, 4'd0,  1'b1,
                             '{STS_EMPTY,     4'd0, 32'h0, 5'd0}});
    directed_ops.push_back('{FN_FIND,         32'h0000_0000, 4'd0,  1'b1,
                             '{STS_NOT_FOUND, 4'd0, 32'h0, 5'd0}});
    directed_ops.push_back('{FN_REMOVE_AT,    32'hFFFF_FFFF, 4'd15, 1'b1,
                             '{STS_EMPTY,     4'd0, 32'h0, 5'd0}});
    directed_ops.push_back('{FN_REMOVE_MATCH, 32'hFFFF_FFFF, 4'd0,  1'b1,
                             '{STS_NOT_FOUND, 4'd0, 32'h0, 5'd0}});
    directed_ops.push_back('{FN_PUSH,         32'hFFFF_FFFF, 4'd15, 1'b1,
                             '{STS_OK,        4'd0, 32'h0, 5'd1}});
    directed_ops.push_back('{FN_PUSH,         32'h0000_0000, 4'd0,  1'b1,
                             '{STS_OK,        4'd0, 32'h0, 5'd2}});
    directed_ops.push_back('{FN_PUSH,         32'hA5A5_A5A5, 4'd0,  1'b1,
                             '{STS_OK,        4'd0, 32'h0, 5'd3}});
    directed_ops.push_back('{FN_PUSH,         32'h5A5A_5A5A, 4'd0,  1'b1,
                             '{STS_OK,        4'd0, 32'h0, 5'd4}});
    directed_ops.push_back('{FN_PEEK,         32'h0000_0000, 4'd15, 1'b1,
                             '{STS_EMPTY,     4'd0, 32'h0, 5'd4}});
    directed_ops.push_back('{FN_PEEK,         32'h0000_0000, 4'd0,  1'b1,
                             '{STS_OK,        4'd0, 32'hFFFF_FFFF, 5'd4}});
    directed_ops.push_back('{FN_PEEK,         32'h0000_0000, 4'd3,  1'b0, '0});
    directed_ops.push_back('{FN_FIND,         32'h0000_0000, 4'd0,  1'b0, '0});
    directed_ops.push_back('{FN_FIND,         32'h1234_5678, 4'd0,  1'b1,
                             '{STS_NOT_FOUND, 4'd0, 32'h0, 5'd4}});
    directed_ops.push_back('{FN_REMOVE_AT,    32'h0000_0000, 4'd1,  1'b0, '0});
    directed_ops.push_back('{FN_REMOVE_MATCH, 32'hA5A5_A5A5, 4'd0,  1'b0, '0});
    directed_ops.push_back('{FN_POP,          32'h0000_0000, 4'd0,  1'b0, '0});
    directed_ops.push_back('{FN_UNUSED,       32'hFFFF_FFFF, 4'd15, 1'b0, '0});
    directed_ops.push_back('{FN_PUSH,         32'h0000_0001, 4'd0,  1'b0, '0});
    directed_ops.push_back('{FN_CLEAR,        32'hFFFF_FFFF, 4'd15, 1'b1,
                             '{STS_OK,        4'd0, 32'h0, 5'd0}});
    directed_ops.push_back('{FN_POP,          32'h0000_0000, 4'd0,  1'b1,
                             '{STS_EMPTY,     4'd0, 32'h0, 5'd0}});

    // Masks for the random phases: all ones, low half, zero (everything matches),
    // top bit only, a random one, and back to all ones
    mask_plan[0] = 32'hFFFF_FFFF;
    mask_plan[1] = 32'h0000_FFFF;
    mask_plan[2] = 32'h0000_0000;
    mask_plan[3] = 32'h8000_0000;
    mask_plan[4] = $urandom();
    mask_plan[5] = 32'hFFFF_FFFF;

    // Hold reset, then release it
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: no idling, so items run back to back
    foreach (directed_ops[i]) begin
      row = directed_ops[i];
      send_op(row.fn, row.key, row.pos, row.typed, row.exp);
    end

    // Random phases, each behind a mask write with the block idle
    for (int p = 0; p < 6; p++) begin
      write_mask(mask_plan[p]);
      tx_idle_on = (p % 3) != 0;
      rx_idle_on = (p % 2) != 0;
      // phase 2: shut the result side for a long stretch while items keep coming
      if (p == 2) hold_off_req = 1'b1;
      run_random_ops(ITEMS_PER_PHASE, p == 0 || p == 3);
    end

    // Wind down: let every result come home, then watch for strays
    drain_results();
    repeat (END_SLACK) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
